// File: hw/rtl/iafp_pkg.sv
// ----------------------------------------------------------------------------
// iafp_pkg
// Shared types and constants of the IMU angle frame parser.
// ----------------------------------------------------------------------------
package iafp_pkg;

	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;
	localparam int         STORED_LEN = 7;
	localparam int         IDX_W      = 4;
	localparam int         Q_DEPTH    = 2;
	localparam int         Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int         Q_CNT_W    = $clog2(Q_DEPTH + 1);

	// degrees = floor(raw * 45 / 64)
	localparam logic signed [6:0] SCALE_MUL = 7'sd45;
	localparam int                SCALE_SHR = 6;

	typedef logic [7:0] byte_t;

	// raw angle words of one completed frame
	typedef struct packed {
		logic signed [15:0] roll_raw;
		logic signed [15:0] pitch_raw;
		logic signed [15:0] yaw_raw;
	} frame_t;

	// queue handshake between front and back
	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: hw/rtl/iafp_front.sv
// ----------------------------------------------------------------------------
// iafp_front
// Byte parser: hunts for the header, stores type and angle bytes, and pushes
// the raw angle words of each completed frame into the queue.
// ----------------------------------------------------------------------------
module iafp_front #(
	parameter int FRAME_LEN = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [7:0]      rx_byte,
	input  iafp_pkg::q_stat_t q_stat,
	output logic            full,
	output logic            q_push,
	output iafp_pkg::frame_t  q_data
);
	import iafp_pkg::*;

	localparam logic ST_HUNT  = 1'b0;
	localparam logic ST_FRAME = 1'b1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

	logic             state_q;
	logic [IDX_W-1:0] byte_index_q;
	byte_t            bytes_q [STORED_LEN];
	byte_t            bytes_n [STORED_LEN];
	logic             accept;
	logic             type_bad;
	logic             done;

	assign full   = q_stat.full;
	assign accept = push && !full;

	// stored bytes with the current beat merged in
	always_comb begin
		for (int k = 0; k < STORED_LEN; k++) begin
			bytes_n[k] = (byte_index_q == IDX_W'(k)) ? rx_byte : bytes_q[k];
		end
	end

	assign type_bad = (byte_index_q == '0) && (rx_byte != TYPE_ANGLE);
	assign done     = accept && (state_q == ST_FRAME) && !type_bad
	                  && (byte_index_q == LAST_IDX);

	assign q_push          = done;
	assign q_data.roll_raw  = {bytes_n[2], bytes_n[1]};
	assign q_data.pitch_raw = {bytes_n[4], bytes_n[3]};
	assign q_data.yaw_raw   = {bytes_n[6], bytes_n[5]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_HUNT;
			byte_index_q <= '0;
		end else if (accept) begin
			unique case (state_q)
				ST_HUNT: begin
					if (rx_byte == HDR_BYTE) state_q <= ST_FRAME;
				end
				ST_FRAME: begin
					if (type_bad) begin
						// wrong type: a header byte restarts the frame
						if (rx_byte != HDR_BYTE) state_q <= ST_HUNT;
						byte_index_q <= '0;
					end else if (byte_index_q == LAST_IDX) begin
						state_q      <= ST_HUNT;
						byte_index_q <= '0;
					end else begin
						byte_index_q <= byte_index_q + 1'b1;
					end
				end
				default: state_q <= ST_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && state_q == ST_FRAME) begin
			for (int k = 0; k < STORED_LEN; k++) begin
				bytes_q[k] <= bytes_n[k];
			end
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q <= LAST_IDX)
		else $error("byte index past frame end");
	a_hunt_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HUNT |-> byte_index_q == '0)
		else $error("index not cleared while hunting");

endmodule

// File: hw/rtl/iafp_queue.sv
// ----------------------------------------------------------------------------
// iafp_queue
// Two-entry queue of raw frames between the parser and the scaler.
// ----------------------------------------------------------------------------
module iafp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  iafp_pkg::q_ctrl_t q_ctrl,
	input  iafp_pkg::frame_t  wr_data,
	output iafp_pkg::q_stat_t q_stat,
	output iafp_pkg::frame_t  rd_data
);
	import iafp_pkg::*;

	frame_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign q_stat.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push      = q_ctrl.push && !q_stat.full;
	assign do_pop       = q_ctrl.pop && !q_stat.empty;
	assign rd_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_data;
	end

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count overflow");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		q_ctrl.push |-> !q_stat.full)
		else $error("frame pushed into full queue");

endmodule

// File: hw/rtl/iafp_back.sv
// ----------------------------------------------------------------------------
// iafp_back
// Scales raw angle words to degrees and holds the result for the receiver.
// ----------------------------------------------------------------------------
module iafp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  iafp_pkg::q_stat_t   q_stat,
	input  iafp_pkg::frame_t    rd_data,
	input  logic                pop,
	output logic                q_pop,
	output logic                empty,
	output logic signed [15:0]  roll_deg,
	output logic signed [15:0]  pitch_deg,
	output logic signed [15:0]  yaw_deg
);
	import iafp_pkg::*;

	logic valid_q;
	logic load;

	function automatic logic signed [15:0] to_deg(input logic signed [15:0] raw);
		logic signed [22:0] prod;
		prod = raw * SCALE_MUL;
		// arithmetic shift gives floor rounding
		return prod[SCALE_SHR +: 16];
	endfunction

	assign empty = !valid_q;
	assign load  = !q_stat.empty && (!valid_q || pop);
	assign q_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			roll_deg  <= to_deg(rd_data.roll_raw);
			pitch_deg <= to_deg(rd_data.pitch_raw);
			yaw_deg   <= to_deg(rd_data.yaw_raw);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !pop |=> valid_q && $stable(roll_deg) && $stable(yaw_deg))
		else $error("result changed before it was taken");

endmodule

// File: hw/rtl/imu_angle_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_angle_frame_parser
// Serial angle-packet parser: bytes in, roll/pitch/yaw in degrees out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received serial byte per beat on rx_byte, taken on
//   a clock edge with push high and full low. A 0x55 byte opens a frame; the
//   type byte must be 0x53, then six angle bytes (little-endian pairs) and
//   trailing bytes up to FRAME_LEN are counted. No checksum is checked.
//   Result channel: queue style. While empty is low the oldest result sits
//   on roll_deg / pitch_deg / yaw_deg (signed, 7 fraction bits,
//   floor(raw*45/64)); pop high with empty low takes it.
//   Throughput: one byte per cycle while full is low, set by the single-cycle parser.
//   Path: once the last frame byte is taken, the frame is written into the
//   queue, then scaled by the multiply into the output register.
//   Stall: results collect in a two-entry queue plus the output register;
//   full rises only when both queue entries are held, i.e. after the
//   receiver stalls over several frames, and rx bytes then wait.
//   Reset (arst_n low): parser hunts for a header, queue and output empty.
// ----------------------------------------------------------------------------
module imu_angle_frame_parser #(
	parameter int FRAME_LEN = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_byte,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] roll_deg,
	output logic signed [15:0] pitch_deg,
	output logic signed [15:0] yaw_deg
);
	import iafp_pkg::*;

	q_ctrl_t q_ctrl;
	q_stat_t q_stat;
	frame_t  wr_frame;
	frame_t  rd_frame;
	logic    q_push;
	logic    q_pop;

	assign q_ctrl.push = q_push;
	assign q_ctrl.pop  = q_pop;

	// front: header hunt, byte store, frame completion
	iafp_front #(
		.FRAME_LEN (FRAME_LEN)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rx_byte (rx_byte),
		.q_stat  (q_stat),
		.full    (full),
		.q_push  (q_push),
		.q_data  (wr_frame)
	);

	// decoupling queue of raw frames
	iafp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_ctrl  (q_ctrl),
		.wr_data (wr_frame),
		.q_stat  (q_stat),
		.rd_data (rd_frame)
	);

	// back: degree scaling and output register
	iafp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.rd_data   (rd_frame),
		.pop       (pop),
		.q_pop     (q_pop),
		.empty     (empty),
		.roll_deg  (roll_deg),
		.pitch_deg (pitch_deg),
		.yaw_deg   (yaw_deg)
	);

endmodule

// File: tb/sv/tb_imu_angle_frame_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_imu_angle_frame_parser
// Self-checking bench for the IMU angle frame parser. Serial bytes go in
// through the push/full side. A byte-level model of the framing state machine
// predicts each roll/pitch/yaw result. Every result beat taken on the
// pop/empty side is checked against the oldest prediction. Both sides
// idle in random bursts, except in parts of the random test and at full rate.
// ----------------------------------------------------------------------------
module tb_imu_angle_frame_parser;

	import iafp_pkg::*;

	localparam int FRAME_LEN  = 10;
	localparam int WDOG_LIMIT = 1000;  // cycles with no beat on either side
	localparam int TAIL_WAIT  = 20;
	localparam int RAND_BYTES = 1000;

	typedef struct {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
	} angles_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [7:0]         rx_byte = 8'h00;
	logic               empty;
	logic               pop = 1'b0;
	logic signed [15:0] roll_deg;
	logic signed [15:0] pitch_deg;
	logic signed [15:0] yaw_deg;

	// predictor state: mirrors the parser's framing logic
	bit          hunting_done = 1'b0;   // set once a header opened the frame
	logic [3:0]  frame_pos = '0;
	logic [7:0]  frame_buf [STORED_LEN];
	angles_t     pending_angles [$];
	int unsigned useful_bytes = 0;      // bytes the parser did not just drop

	bit          idle_en = 1'b1;
	int unsigned pop_hold = 0;
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;

	imu_angle_frame_parser #(
		.FRAME_LEN(FRAME_LEN)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.rx_byte  (rx_byte),
		.empty    (empty),
		.pop      (pop),
		.roll_deg (roll_deg),
		.pitch_deg(pitch_deg),
		.yaw_deg  (yaw_deg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// floor(raw * 180 * 128 / 32768) = floor(raw * 45 / 64)
	function automatic logic signed [15:0] to_degrees(input logic [7:0] lo,
	                                                  input logic [7:0] hi);
		int raw;
		int deg;
		raw = $signed({hi, lo});
		deg = (raw * 45) >>> 6;
		return deg[15:0];
	endfunction

	task automatic parse_byte(input logic [7:0] b);
		angles_t a;
		if (!hunting_done) begin
			if (b == HDR_BYTE) begin
				hunting_done = 1'b1;
				useful_bytes++;
			end
			return;
		end
		useful_bytes++;
		if (frame_pos < STORED_LEN)
			frame_buf[frame_pos] = b;
		frame_pos = frame_pos + 4'd1;
		// wrong type byte: a header restarts the frame, anything else hunts
		if (frame_pos == 4'd1 && frame_buf[0] != TYPE_ANGLE) begin
			if (b != HDR_BYTE)
				hunting_done = 1'b0;
			frame_pos = '0;
			return;
		end
		if (frame_pos >= FRAME_LEN) begin
			a.roll  = to_degrees(frame_buf[1], frame_buf[2]);
			a.pitch = to_degrees(frame_buf[3], frame_buf[4]);
			a.yaw   = to_degrees(frame_buf[5], frame_buf[6]);
			pending_angles.push_back(a);
			hunting_done = 1'b0;
			frame_pos = '0;
		end
	endtask

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// one beat; the edge sample of full decides acceptance
	task automatic send_byte(input logic [7:0] b);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		parse_byte(b);
	endtask

	// header, type, three LE angle words, then random trailing bytes
	task automatic send_frame(input logic [15:0] r, input logic [15:0] p,
	                          input logic [15:0] y);
		send_byte(HDR_BYTE);
		send_byte(TYPE_ANGLE);
		send_byte(r[7:0]);
		send_byte(r[15:8]);
		send_byte(p[7:0]);
		send_byte(p[15:8]);
		send_byte(y[7:0]);
		send_byte(y[15:8]);
		repeat (FRAME_LEN - STORED_LEN) send_byte(8'($urandom));
	endtask

	function automatic logic [15:0] pick_angle();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// hold off the sender until every predicted result has come out
	task automatic drain_results();
		push <= 1'b0;
		while (pending_angles.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (pop_hold != 0) begin
			pop_hold <= pop_hold - 1;
			pop <= 1'b0;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			pop_hold <= $urandom_range(0, 7);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic note_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin : check_beat
		angles_t want;
		if (arst_n && pop && !empty) begin
			if (pending_angles.size() == 0) begin
				note_error($sformatf("unexpected beat roll=%0d pitch=%0d yaw=%0d",
					roll_deg, pitch_deg, yaw_deg));
			end else begin
				want = pending_angles.pop_front();
				if (roll_deg !== want.roll)
					note_error($sformatf("roll exp %0d got %0d", want.roll, roll_deg));
				if (pitch_deg !== want.pitch)
					note_error($sformatf("pitch exp %0d got %0d", want.pitch, pitch_deg));
				if (yaw_deg !== want.yaw)
					note_error($sformatf("yaw exp %0d got %0d", want.yaw, yaw_deg));
			end
		end
	end

	// watchdog: too long without a beat on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("watchdog expired with %0d results pending", pending_angles.size());
			$display("imu_angle_frame_parser test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// extremes and small raw words: -32768, 32767, -1, 0, 1, -128
	task automatic test_angle_extremes();
		send_frame(16'h8000, 16'h7FFF, 16'hFFFF);
		send_frame(16'h0000, 16'h0001, 16'hFF80);
	endtask

	// noise while hunting; header then header restarts; bad type drops back
	task automatic test_wrong_type();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(TYPE_ANGLE);      // type byte with no header: dropped
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);        // bad type but a header: frame restarts
		send_frame(16'h1234, 16'hEDCB, 16'h0040);
		send_byte(HDR_BYTE);
		send_byte(8'hA7);           // bad type: back to hunting
		send_byte(TYPE_ANGLE);
		send_byte(8'hAA);
	endtask

	// 0x55 past the type byte is data, in angle bytes and trailing bytes
	task automatic test_header_in_frame();
		send_byte(HDR_BYTE);
		send_byte(TYPE_ANGLE);
		repeat (FRAME_LEN - 1) send_byte(HDR_BYTE);
	endtask

	// mostly good frames, with noise, bad types and cut-short frames mixed in
	task automatic test_random_frames();
		int unsigned goal;
		int unsigned pick;
		int unsigned frames;
		goal = useful_bytes + RAND_BYTES;
		frames = 0;
		while (useful_bytes < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				send_frame(pick_angle(), pick_angle(), pick_angle());
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end else if (pick < 93) begin
				send_byte(HDR_BYTE);
				send_byte($urandom_range(0, 1) ? HDR_BYTE : 8'($urandom));
			end else begin
				send_byte(HDR_BYTE);
				send_byte(TYPE_ANGLE);
				repeat ($urandom_range(0, FRAME_LEN - 2)) send_byte(8'($urandom));
			end
			frames++;
			if (frames % 20 == 0)
				idle_en = ($urandom_range(0, 3) != 0);
			if (frames == 60)
				drain_results();
		end
		idle_en = 1'b1;
	endtask

	// sender pause with results still in flight
	task automatic test_drain_pause();
		send_frame(pick_angle(), pick_angle(), pick_angle());
		send_frame(pick_angle(), pick_angle(), pick_angle());
		drain_results();
		send_frame(pick_angle(), pick_angle(), pick_angle());
	endtask

	// last part: byte every cycle, pop every cycle
	task automatic test_full_rate();
		idle_en = 1'b0;
		repeat (20) send_frame(pick_angle(), pick_angle(), pick_angle());
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_angle_extremes();
		test_wrong_type();
		test_header_in_frame();
		test_drain_pause();
		test_random_frames();
		test_full_rate();

		push <= 1'b0;
		while (pending_angles.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (pending_angles.size() != 0)
			note_error($sformatf("%0d results never came", pending_angles.size()));

		if (errors == 0) begin
			$display("imu_angle_frame_parser test passed");
		end else begin
			$display("imu_angle_frame_parser test failed");
		end
		$finish;
	end

endmodule
